### rtl/core/point_segment_nearest_distance_top_assert.svh
// Assertion macros for the nearest-point-on-segment block.
// Expects clk and arst_n in the scope where the macros are used.
`ifndef POINT_SEGMENT_NEAREST_DISTANCE_TOP_ASSERT_SVH
`define POINT_SEGMENT_NEAREST_DISTANCE_TOP_ASSERT_SVH

// antecedent implies consequent on the same edge
`define PSND_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("psnd: implication check failed");

// condition must never hold
`define PSND_ASSERT_NEVER(lbl, cond) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
	else $error("psnd: forbidden condition seen");

`endif

### rtl/core/psnd_pkg.sv
// Shared constants and types for the nearest-point-on-segment block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package psnd_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int DIST_WIDTH      = 17;
	localparam int WHERE_WIDTH     = 2;

	typedef logic [WHERE_WIDTH-1:0] where_t;

	localparam where_t WHERE_INTERIOR = 2'd0;
	localparam where_t WHERE_END_A    = 2'd1;
	localparam where_t WHERE_END_B    = 2'd2;
	localparam where_t WHERE_RSVD     = 2'd3;

endpackage
`default_nettype wire

### rtl/core/psnd_front.sv
// Front pipeline: differences, dot products, classification, and the
// dividend/divisor of the projection. Five stages. Uses psnd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module psnd_front #(
	parameter int W = psnd_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire logic                    in_valid,
	input  wire logic signed [W-1:0]     px,
	input  wire logic signed [W-1:0]     py,
	input  wire logic signed [W-1:0]     ax,
	input  wire logic signed [W-1:0]     ay,
	input  wire logic signed [W-1:0]     bx,
	input  wire logic signed [W-1:0]     by,
	output logic                         out_valid,
	output logic [3*W+2:0]               dvd_x,
	output logic [3*W+2:0]               dvd_y,
	output logic [2*W+1:0]               dvs,
	output psnd_pkg::where_t             where,
	output logic                         neg_x,
	output logic                         neg_y,
	output logic [6*W-1:0]               crd
);
	localparam int DW   = W + 1;
	localparam int PW   = 2 * DW;
	localparam int NUMW = PW + 1;
	localparam int MW   = 3 * W + 1;
	localparam int NW   = 3 * W + 3;
	localparam int DDW  = 2 * W + 2;

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [DW-1:0]   dx_s1, dy_s1, pax_s1, pay_s1, pbx_s1, pby_s1;
	logic signed [PW-1:0]   pxd_s2, pyd_s2, dxx_s2, dyy_s2, paa_s2, pab_s2, pba_s2, pbb_s2;
	logic [W-1:0]           adx_s2, ady_s2, adx_s3, ady_s3;
	logic                   nx_s2, ny_s2, nx_s3, ny_s3, nx_s4, ny_s4;
	logic signed [NUMW-1:0] num_s3, den_s3, da_s3, db_s3;
	logic [MW-1:0]          mx_s4, my_s4;
	logic [2*W:0]           den_s4;
	psnd_pkg::where_t       wh_s4, wh_s5;
	logic [NW-1:0]          nmx_s5, nmy_s5;
	logic [DDW-1:0]         dvs_s5;
	logic [6*W-1:0]         crd_s1, crd_s2, crd_s3, crd_s4, crd_s5;
	logic [DW-1:0]          adx_w, ady_w;
	psnd_pkg::where_t       wh_w;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// magnitudes of the segment direction
	always_comb begin
		adx_w = dx_s1[DW-1] ? (~dx_s1 + 1'b1) : dx_s1;
		ady_w = dy_s1[DW-1] ? (~dy_s1 + 1'b1) : dy_s1;
	end

	// classify: zero length, interior, or nearer end
	always_comb begin
		if (den_s3 == '0) begin
			wh_w = psnd_pkg::WHERE_END_A;
		end else if (!num_s3[NUMW-1] && (num_s3 <= den_s3)) begin
			wh_w = psnd_pkg::WHERE_INTERIOR;
		end else if (da_s3 <= db_s3) begin
			wh_w = psnd_pkg::WHERE_END_A;
		end else begin
			wh_w = psnd_pkg::WHERE_END_B;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: differences
			dx_s1  <= {bx[W-1], bx} - {ax[W-1], ax};
			dy_s1  <= {by[W-1], by} - {ay[W-1], ay};
			pax_s1 <= {px[W-1], px} - {ax[W-1], ax};
			pay_s1 <= {py[W-1], py} - {ay[W-1], ay};
			pbx_s1 <= {px[W-1], px} - {bx[W-1], bx};
			pby_s1 <= {py[W-1], py} - {by[W-1], by};
			crd_s1 <= {px, py, ax, ay, bx, by};
			// s2: products
			pxd_s2 <= pax_s1 * dx_s1;
			pyd_s2 <= pay_s1 * dy_s1;
			dxx_s2 <= dx_s1 * dx_s1;
			dyy_s2 <= dy_s1 * dy_s1;
			paa_s2 <= pax_s1 * pax_s1;
			pab_s2 <= pay_s1 * pay_s1;
			pba_s2 <= pbx_s1 * pbx_s1;
			pbb_s2 <= pby_s1 * pby_s1;
			adx_s2 <= adx_w[W-1:0];
			ady_s2 <= ady_w[W-1:0];
			nx_s2  <= dx_s1[DW-1];
			ny_s2  <= dy_s1[DW-1];
			crd_s2 <= crd_s1;
			// s3: sums
			num_s3 <= pxd_s2 + pyd_s2;
			den_s3 <= dxx_s2 + dyy_s2;
			da_s3  <= paa_s2 + pab_s2;
			db_s3  <= pba_s2 + pbb_s2;
			adx_s3 <= adx_s2;
			ady_s3 <= ady_s2;
			nx_s3  <= nx_s2;
			ny_s3  <= ny_s2;
			crd_s3 <= crd_s2;
			// s4: classify and scale num by |d|
			wh_s4  <= wh_w;
			mx_s4  <= num_s3[2*W:0] * adx_s3;
			my_s4  <= num_s3[2*W:0] * ady_s3;
			den_s4 <= den_s3[2*W:0];
			nx_s4  <= nx_s3;
			ny_s4  <= ny_s3;
			crd_s4 <= crd_s3;
			// s5: rounding dividend; negative axis drops one for the floor
			nmx_s5 <= NW'({mx_s4, 1'b0}) + NW'(den_s4) - NW'(nx_s4);
			nmy_s5 <= NW'({my_s4, 1'b0}) + NW'(den_s4) - NW'(ny_s4);
			dvs_s5 <= {den_s4, 1'b0};
			wh_s5  <= wh_s4;
			crd_s5 <= crd_s4;
			neg_x  <= nx_s4;
			neg_y  <= ny_s4;
		end
	end

	assign out_valid = v_s5;
	assign dvd_x     = nmx_s5;
	assign dvd_y     = nmy_s5;
	assign dvs       = dvs_s5;
	assign where     = wh_s5;
	assign crd       = crd_s5;

endmodule
`default_nettype wire

### rtl/core/psnd_div.sv
// Pipelined restoring divider, one quotient bit per stage, two dividends
// sharing one divisor, with a sideband carried alongside. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module psnd_div #(
	parameter int NW  = 51,
	parameter int DDW = 34,
	parameter int QB  = 16,
	parameter int SBW = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           in_valid,
	input  wire logic [NW-1:0]  dvd_x,
	input  wire logic [NW-1:0]  dvd_y,
	input  wire logic [DDW-1:0] dvs,
	input  wire logic [SBW-1:0] sb_in,
	output logic                out_valid,
	output logic [QB-1:0]       quo_x,
	output logic [QB-1:0]       quo_y,
	output logic [SBW-1:0]      sb_out
);
	logic           v_s  [QB];
	logic [NW-1:0]  rx_s [QB];
	logic [NW-1:0]  ry_s [QB];
	logic [DDW-1:0] d_s  [QB];
	logic [QB-1:0]  qx_s [QB];
	logic [QB-1:0]  qy_s [QB];
	logic [SBW-1:0] sb_s [QB];

	for (genvar i = 0; i < QB; i++) begin : g_stg
		localparam int B = QB - 1 - i;
		logic           v_i;
		logic [NW-1:0]  rx_i, ry_i, sh;
		logic [DDW-1:0] d_i;
		logic [QB-1:0]  qx_i, qy_i;
		logic [SBW-1:0] sb_i;
		logic           gx, gy;

		if (i == 0) begin : g_first
			assign v_i  = in_valid;
			assign rx_i = dvd_x;
			assign ry_i = dvd_y;
			assign d_i  = dvs;
			assign qx_i = '0;
			assign qy_i = '0;
			assign sb_i = sb_in;
		end else begin : g_next
			assign v_i  = v_s[i-1];
			assign rx_i = rx_s[i-1];
			assign ry_i = ry_s[i-1];
			assign d_i  = d_s[i-1];
			assign qx_i = qx_s[i-1];
			assign qy_i = qy_s[i-1];
			assign sb_i = sb_s[i-1];
		end

		// trial subtract of the divisor at this bit weight
		assign sh = NW'(d_i) << B;
		assign gx = (rx_i >= sh);
		assign gy = (ry_i >= sh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (adv) begin
				v_s[i] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rx_s[i] <= gx ? (rx_i - sh) : rx_i;
				ry_s[i] <= gy ? (ry_i - sh) : ry_i;
				qx_s[i] <= {qx_i[QB-2:0], gx};
				qy_s[i] <= {qy_i[QB-2:0], gy};
				d_s[i]  <= d_i;
				sb_s[i] <= sb_i;
			end
		end
	end

	assign out_valid = v_s[QB-1];
	assign quo_x     = qx_s[QB-1];
	assign quo_y     = qy_s[QB-1];
	assign sb_out    = sb_s[QB-1];

endmodule
`default_nettype wire

### rtl/core/psnd_sqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband
// carried alongside. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module psnd_sqrt #(
	parameter int SW  = 34,
	parameter int SBW = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           adv,
	input  wire logic           in_valid,
	input  wire logic [SW-1:0]  rad,
	input  wire logic [SBW-1:0] sb_in,
	output logic                out_valid,
	output logic [SW/2-1:0]     root,
	output logic [SBW-1:0]      sb_out
);
	localparam int NS = SW / 2;

	logic           v_s  [NS];
	logic [SW-1:0]  rm_s [NS];
	logic [SW-1:0]  rs_s [NS];
	logic [SBW-1:0] sb_s [NS];

	for (genvar i = 0; i < NS; i++) begin : g_stg
		logic           v_i;
		logic [SW-1:0]  rm_i, rs_i, bt, t;
		logic [SBW-1:0] sb_i;
		logic           ge;

		if (i == 0) begin : g_first
			assign v_i  = in_valid;
			assign rm_i = rad;
			assign rs_i = '0;
			assign sb_i = sb_in;
		end else begin : g_next
			assign v_i  = v_s[i-1];
			assign rm_i = rm_s[i-1];
			assign rs_i = rs_s[i-1];
			assign sb_i = sb_s[i-1];
		end

		// trial bit at weight 4^(NS-1-i)
		assign bt = SW'(1) << (SW - 2 - 2 * i);
		assign t  = rs_i + bt;
		assign ge = (rm_i >= t);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (adv) begin
				v_s[i] <= v_i;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rm_s[i] <= ge ? (rm_i - t) : rm_i;
				rs_s[i] <= ge ? ((rs_i >> 1) + bt) : (rs_i >> 1);
				sb_s[i] <= sb_i;
			end
		end
	end

	assign out_valid = v_s[NS-1];
	assign root      = rs_s[NS-1][NS-1:0];
	assign sb_out    = sb_s[NS-1];

endmodule
`default_nettype wire

### rtl/core/point_segment_nearest_distance_top.sv
// Top level: nearest point on a segment and the distance to it.
// Uses psnd_pkg, psnd_front, psnd_div, psnd_sqrt and the assertion header.
`timescale 1ns / 1ps
`default_nettype none
// Takes one query (point P, segment ends A and B) per clock and returns the
// nearest point on the segment, floor of the Euclidean distance to it, and
// whether it lies inside the segment or at an end. All coordinates share one
// fixed-point scale, so the fraction bit count does not enter the arithmetic.
// Throughput is one transfer per cycle while no result waits on m_tready;
// the pipeline includes the projection divider (COORD_WIDTH stages, one
// quotient bit each) and the square root (COORD_WIDTH+1 stages).
// The whole pipeline holds while a result waits on m_tready.
module point_segment_nearest_distance_top #(
	parameter int COORD_WIDTH = psnd_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// point_x, point_y, seg_a_x, seg_a_y, seg_b_x, seg_b_y
	input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// near_x, near_y, dist_res, where_found, zero pad
	output logic [((2*COORD_WIDTH+19+7)/8)*8-1:0]   m_tdata
);
	localparam int W    = COORD_WIDTH;
	localparam int DW   = W + 1;
	localparam int PW   = 2 * DW;
	localparam int NW   = 3 * W + 3;
	localparam int DDW  = 2 * W + 2;
	localparam int SW   = 2 * W + 2;
	localparam int RB   = SW / 2;
	localparam int DSW  = psnd_pkg::DIST_WIDTH;
	localparam int TDW  = ((2 * W + 19 + 7) / 8) * 8;
	localparam int SB1  = 4 + 6 * W;
	localparam int SB2  = 2 + 2 * W;

	logic                 adv;
	logic                 fv;
	logic [NW-1:0]        dvd_x, dvd_y;
	logic [DDW-1:0]       dvs;
	psnd_pkg::where_t     f_where;
	logic                 f_negx, f_negy;
	logic [6*W-1:0]       f_crd;
	logic                 dv;
	logic [W-1:0]         qx, qy;
	logic [SB1-1:0]       dsb;
	psnd_pkg::where_t     d_where;
	logic                 d_negx, d_negy;
	logic [W-1:0]         d_px, d_py, d_ax, d_ay, d_bx, d_by;
	logic [DW-1:0]        ix_w, iy_w, qxe, qye;
	logic [W-1:0]         nx_w, ny_w;
	logic                 v_s1, v_s2, v_s3, v_s4;
	psnd_pkg::where_t     wh_s1, wh_s2, wh_s3, wh_s4;
	logic [W-1:0]         nx_s1, ny_s1, px_s1, py_s1;
	logic [W-1:0]         nx_s2, ny_s2, nx_s3, ny_s3, nx_s4, ny_s4;
	logic signed [DW-1:0] ex_s2, ey_s2;
	logic signed [PW-1:0] sqx_s3, sqy_s3;
	logic [SW-1:0]        d2_s4;
	logic                 rv;
	logic [RB-1:0]        root;
	logic [SB2-1:0]       rsb;
	logic [RB+DSW-1:0]    dist_ext;

	// whole pipeline moves unless the output holds an untaken result
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	psnd_front #(.W(W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (s_tvalid),
		.px       (s_tdata[W-1:0]),
		.py       (s_tdata[2*W-1:W]),
		.ax       (s_tdata[3*W-1:2*W]),
		.ay       (s_tdata[4*W-1:3*W]),
		.bx       (s_tdata[5*W-1:4*W]),
		.by       (s_tdata[6*W-1:5*W]),
		.out_valid(fv),
		.dvd_x    (dvd_x),
		.dvd_y    (dvd_y),
		.dvs      (dvs),
		.where    (f_where),
		.neg_x    (f_negx),
		.neg_y    (f_negy),
		.crd      (f_crd)
	);

	psnd_div #(.NW(NW), .DDW(DDW), .QB(W), .SBW(SB1)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (fv),
		.dvd_x    (dvd_x),
		.dvd_y    (dvd_y),
		.dvs      (dvs),
		.sb_in    ({f_where, f_negx, f_negy, f_crd}),
		.out_valid(dv),
		.quo_x    (qx),
		.quo_y    (qy),
		.sb_out   (dsb)
	);

	assign {d_where, d_negx, d_negy, d_px, d_py, d_ax, d_ay, d_bx, d_by} = dsb;

	// nearest point: A plus the signed rounded step when interior, else the chosen end
	always_comb begin
		qxe  = {1'b0, qx};
		qye  = {1'b0, qy};
		ix_w = {d_ax[W-1], d_ax} + (d_negx ? (~qxe + 1'b1) : qxe);
		iy_w = {d_ay[W-1], d_ay} + (d_negy ? (~qye + 1'b1) : qye);
		unique case (d_where)
			psnd_pkg::WHERE_INTERIOR: begin
				nx_w = ix_w[W-1:0];
				ny_w = iy_w[W-1:0];
			end
			psnd_pkg::WHERE_END_B: begin
				nx_w = d_bx;
				ny_w = d_by;
			end
			default: begin
				nx_w = d_ax;
				ny_w = d_ay;
			end
		endcase
	end

	// valid chain for the compose/error/square/sum stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= dv;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// s1 nearest point, s2 error vector, s3 squares, s4 squared distance
	always_ff @(posedge clk) begin
		if (adv) begin
			nx_s1  <= nx_w;
			ny_s1  <= ny_w;
			px_s1  <= d_px;
			py_s1  <= d_py;
			wh_s1  <= d_where;
			ex_s2  <= {px_s1[W-1], px_s1} - {nx_s1[W-1], nx_s1};
			ey_s2  <= {py_s1[W-1], py_s1} - {ny_s1[W-1], ny_s1};
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			wh_s2  <= wh_s1;
			sqx_s3 <= ex_s2 * ex_s2;
			sqy_s3 <= ey_s2 * ey_s2;
			nx_s3  <= nx_s2;
			ny_s3  <= ny_s2;
			wh_s3  <= wh_s2;
			d2_s4  <= $unsigned(sqx_s3) + $unsigned(sqy_s3);
			nx_s4  <= nx_s3;
			ny_s4  <= ny_s3;
			wh_s4  <= wh_s3;
		end
	end

	psnd_sqrt #(.SW(SW), .SBW(SB2)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (v_s4),
		.rad      (d2_s4),
		.sb_in    ({wh_s4, ny_s4, nx_s4}),
		.out_valid(rv),
		.root     (root),
		.sb_out   (rsb)
	);

	// last root stage is the output register
	assign dist_ext = {{DSW{1'b0}}, root};
	assign m_tvalid = rv;
	assign m_tdata  = TDW'({rsb[SB2-1:2*W], dist_ext[DSW-1:0], rsb[2*W-1:0]});

	`include "point_segment_nearest_distance_top_assert.svh"

	`PSND_ASSERT_NEVER(a_where_code_valid, m_tvalid && (m_tdata[2*W+DSW+1:2*W+DSW] == psnd_pkg::WHERE_RSVD))
	`PSND_ASSERT_IMP(a_stall_only_when_held, !s_tready, m_tvalid && !m_tready)
	`PSND_ASSERT_IMP(a_end_b_takes_b, dv && (d_where == psnd_pkg::WHERE_END_B), nx_w == d_bx)

endmodule
`default_nettype wire
